// ----- src/ufold_pkg.sv -----
// ----------------------------------------------------------------------------
// ufold_pkg
// Shared types and character constants of the UTF-8 to ASCII folding filter.
// ----------------------------------------------------------------------------
package ufold_pkg;

  // Decoder mode, one-hot.
  typedef enum logic [3:0] {
    MODE_NORMAL    = 4'b0001,
    MODE_GOT_E2    = 4'b0010,
    MODE_GOT_E2_80 = 4'b0100,
    MODE_SKIPPING  = 4'b1000
  } mode_e;

  // One run: the characters caused by one input byte (cnt is 1 to 3 when queued).
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][6:0] chars;
  } run_t;

  // Byte codes recognized by the decoder.
  localparam logic [7:0] BYTE_HASH = 8'h23;
  localparam logic [7:0] BYTE_E2   = 8'hE2;
  localparam logic [7:0] BYTE_80   = 8'h80;
  localparam logic [7:0] BYTE_EN   = 8'h93;
  localparam logic [7:0] BYTE_EM   = 8'h94;
  localparam logic [7:0] BYTE_LSQ  = 8'h98;
  localparam logic [7:0] BYTE_RSQ  = 8'h99;
  localparam logic [7:0] BYTE_LDQ  = 8'h9C;
  localparam logic [7:0] BYTE_RDQ  = 8'h9D;
  localparam logic [7:0] BYTE_ELL  = 8'hA6;
  localparam logic [7:0] BYTE_BUL  = 8'hA2;

  // Emitted ASCII characters.
  localparam logic [6:0] CH_HASH  = 7'h23;
  localparam logic [6:0] CH_QMARK = 7'h3F;
  localparam logic [6:0] CH_DASH  = 7'h2D;
  localparam logic [6:0] CH_SQ    = 7'h27;
  localparam logic [6:0] CH_DQ    = 7'h22;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_STAR  = 7'h2A;

endpackage

// ----- src/ufold_front.sv -----
// ----------------------------------------------------------------------------
// ufold_front
// Accepts input bytes, tracks the decoder mode and turns each byte into a run.
// ----------------------------------------------------------------------------
module ufold_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              chunk_end_i,
  output logic              run_valid_o,
  output ufold_pkg::run_t   run_o
);

  typedef struct packed {
    ufold_pkg::run_t  run;
    ufold_pkg::mode_e mode;
  } step_t;

  function automatic step_t do_normal(logic [7:0] b, logic e);
    step_t s;
    s.run.cnt   = 2'd0;
    s.run.chars = '0;
    s.mode      = ufold_pkg::MODE_NORMAL;
    if (b == ufold_pkg::BYTE_HASH) begin
      s.run.cnt      = 2'd2;
      s.run.chars[0] = ufold_pkg::CH_HASH;
      s.run.chars[1] = ufold_pkg::CH_HASH;
    end else if (!b[7]) begin
      s.run.cnt      = 2'd1;
      s.run.chars[0] = b[6:0];
    end else if (b == ufold_pkg::BYTE_E2 && !e) begin
      s.mode = ufold_pkg::MODE_GOT_E2;
    end else begin
      s.run.cnt      = 2'd1;
      s.run.chars[0] = ufold_pkg::CH_QMARK;
      s.mode         = e ? ufold_pkg::MODE_NORMAL : ufold_pkg::MODE_SKIPPING;
    end
    return s;
  endfunction

  function automatic step_t do_skip(logic [7:0] b, logic e);
    step_t s;
    s.run.cnt   = 2'd0;
    s.run.chars = '0;
    s.mode      = e ? ufold_pkg::MODE_NORMAL : ufold_pkg::MODE_SKIPPING;
    if (b[7:6] != 2'b10) begin
      s = do_normal(b, e);
    end
    return s;
  endfunction

  function automatic step_t do_fold(logic [7:0] t);
    step_t s;
    s.run.cnt   = 2'd1;
    s.run.chars = '0;
    s.mode      = ufold_pkg::MODE_NORMAL;
    if (t == ufold_pkg::BYTE_EN || t == ufold_pkg::BYTE_EM) begin
      s.run.chars[0] = ufold_pkg::CH_DASH;
    end else if (t == ufold_pkg::BYTE_LSQ || t == ufold_pkg::BYTE_RSQ) begin
      s.run.chars[0] = ufold_pkg::CH_SQ;
    end else if (t == ufold_pkg::BYTE_LDQ || t == ufold_pkg::BYTE_RDQ) begin
      s.run.chars[0] = ufold_pkg::CH_DQ;
    end else if (t == ufold_pkg::BYTE_ELL) begin
      s.run.cnt   = 2'd3;
      s.run.chars = {ufold_pkg::CH_DOT, ufold_pkg::CH_DOT, ufold_pkg::CH_DOT};
    end else if (t == ufold_pkg::BYTE_BUL) begin
      s.run.chars[0] = ufold_pkg::CH_STAR;
    end else begin
      s.run.chars[0] = ufold_pkg::CH_QMARK;
    end
    return s;
  endfunction

  ufold_pkg::mode_e mode_q, mode_d;
  step_t            step;
  step_t            tail;

  always_comb begin
    tail = do_skip(in_byte_i, chunk_end_i);
    unique case (mode_q)
      ufold_pkg::MODE_GOT_E2: begin
        if (in_byte_i == ufold_pkg::BYTE_80 && !chunk_end_i) begin
          step.run.cnt   = 2'd0;
          step.run.chars = '0;
          step.mode      = ufold_pkg::MODE_GOT_E2_80;
        end else begin
          // The held lead becomes '?', followed by whatever this byte gives.
          step.mode           = tail.mode;
          step.run.cnt        = tail.run.cnt + 2'd1;
          step.run.chars[0]   = ufold_pkg::CH_QMARK;
          step.run.chars[2:1] = tail.run.chars[1:0];
        end
      end
      ufold_pkg::MODE_GOT_E2_80: step = do_fold(in_byte_i);
      ufold_pkg::MODE_SKIPPING:  step = tail;
      default:                   step = do_normal(in_byte_i, chunk_end_i);
    endcase
  end

  assign mode_d      = accept_i ? step.mode : mode_q;
  assign run_o       = step.run;
  assign run_valid_o = accept_i && (step.run.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ufold_pkg::MODE_NORMAL;
    end else begin
      mode_q <= mode_d;
    end
  end

`ifndef ASSERT_OFF
  // The third byte of the E2 80 form always produces output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && mode_q == ufold_pkg::MODE_GOT_E2_80) |-> run_valid_o)
    else $error("fold byte produced no run");
  // A chunk end never leaves a sequence pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && chunk_end_i) |=> (mode_q == ufold_pkg::MODE_NORMAL))
    else $error("mode not normal after chunk end");
`endif

endmodule

// ----- src/ufold_queue.sv -----
// ----------------------------------------------------------------------------
// ufold_queue
// Short run queue between the decoder front and the character back end.
// ----------------------------------------------------------------------------
module ufold_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  ufold_pkg::run_t wdata_i,
  output logic            full_o,
  output logic            rd_valid_o,
  output ufold_pkg::run_t rd_data_o,
  input  logic            rd_pop_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLCNT = CW'(DEPTH);

  ufold_pkg::run_t entry_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o     = (count_q == FULLCNT);
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = entry_q[rptr_q];
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_wr) begin
      wptr_d = (wptr_q == LAST) ? '0 : wptr_q + PW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == LAST) ? '0 : rptr_q + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULLCNT)
    else $error("queue count overflow");
  // The front only writes when there is room, so no run is ever dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_i && full_o))
    else $error("run written into full queue");
`endif

endmodule

// ----- src/ufold_back.sv -----
// ----------------------------------------------------------------------------
// ufold_back
// Serializes queued runs into single characters through an output register.
// ----------------------------------------------------------------------------
module ufold_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  ufold_pkg::run_t head_i,
  output logic            head_pop_o,
  input  logic            pop,
  output logic            empty,
  output logic [6:0]      out_char_o,
  output logic            run_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       oval_q, oval_d;
  logic [6:0] char_q, char_d;
  logic       last_q, last_d;
  logic       load, at_last;

  assign load       = head_valid_i && (!oval_q || pop);
  assign at_last    = (idx_q == head_i.cnt - 2'd1);
  assign head_pop_o = load && at_last;

  always_comb begin
    idx_d  = idx_q;
    oval_d = oval_q;
    char_d = char_q;
    last_d = last_q;
    if (load) begin
      oval_d = 1'b1;
      char_d = head_i.chars[idx_q];
      last_d = at_last;
      idx_d  = at_last ? 2'd0 : idx_q + 2'd1;
    end else if (pop) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 2'd0;
      oval_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign empty      = !oval_q;
  assign out_char_o = char_q;
  assign run_last_o = last_q;

`ifndef ASSERT_OFF
  // The character index stays inside the run at the head of the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q < head_i.cnt))
    else $error("character index beyond run");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (idx_q == 2'd0))
    else $error("index not cleared between runs");
`endif

endmodule

// ----- src/utf8_ascii_fold_filter.sv -----
// A byte's first character goes through a queue entry and the output register to the ports.
// Throughput: one byte per cycle while each byte gives at most one character and pop is held;
// output drains one character per cycle while popped, so '#', ellipsis, '?'-prefixed runs lag.
// A 4-run queue between decoder and serializer absorbs those bursts before full rises.
// Reset (rst_ni low, asynchronous) empties the queue and returns the decoder to normal mode.
// ----------------------------------------------------------------------------
// utf8_ascii_fold_filter
// UTF-8 byte stream to 7-bit ASCII with escape doubling and punctuation folding.
// ----------------------------------------------------------------------------
module utf8_ascii_fold_filter #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       chunk_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char_o,
  output logic       run_last_o
);

  logic            accept;
  logic            run_valid;
  ufold_pkg::run_t run;
  logic            head_valid;
  ufold_pkg::run_t head;
  logic            head_pop;

  assign accept = push && !full;

  ufold_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .chunk_end_i (chunk_end_i),
    .run_valid_o (run_valid),
    .run_o       (run)
  );

  ufold_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (run_valid),
    .wdata_i    (run),
    .full_o     (full),
    .rd_valid_o (head_valid),
    .rd_data_o  (head),
    .rd_pop_i   (head_pop)
  );

  ufold_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .pop          (pop),
    .empty        (empty),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o)
  );

endmodule
